// ----- design/hav_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_pkg
// Shared widths, constants, arctangent table and Q30 product helper for the
// great-circle distance pipeline.
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int ANGLE_FRAC_BITS = 28;
  localparam int CORDIC_STAGES   = 24;
  localparam int SQRT_STAGES     = 31;
  localparam int FULL_SH         = 30 - ANGLE_FRAC_BITS;
  localparam int HALF_SH         = 29 - ANGLE_FRAC_BITS;

  localparam int LAT_W   = 30;
  localparam int LON_W   = 31;
  localparam int DIST_W  = 31;
  localparam int W       = 34;
  localparam int SH_W    = 5;
  localparam int ROOT_W  = 31;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = 33;
  localparam int PROD_W  = 47;
  localparam int RAD2_W  = 14;

  localparam int PIPE_DEPTH = 2 + CORDIC_STAGES + 3 + SQRT_STAGES + CORDIC_STAGES + 2;
  localparam int SAT_DEPTH  = SQRT_STAGES + CORDIC_STAGES + 2;

  typedef logic signed [W-1:0] cw_t;

  localparam cw_t GAIN_INV = cw_t'(64'sd652032874);
  localparam cw_t Q30_ONE  = cw_t'(64'sd1073741824);
  localparam cw_t Q30_PI   = cw_t'(64'sd3373259426);
  localparam cw_t TWO_PI   = cw_t'(64'sd6746518852);
  localparam cw_t HALF_PI  = cw_t'(64'sd1686629713);
  localparam logic [RAD2_W-1:0] RAD2 = RAD2_W'(12742);
  localparam logic [32:0] DIST_MAX = 33'd1311708710;

  function automatic cw_t atan_q30(input logic [SH_W-1:0] i);
    cw_t v;
    unique case (i)
      5'd0:  v = cw_t'(64'sd843314856);
      5'd1:  v = cw_t'(64'sd497837829);
      5'd2:  v = cw_t'(64'sd263043836);
      5'd3:  v = cw_t'(64'sd133525158);
      5'd4:  v = cw_t'(64'sd67021686);
      5'd5:  v = cw_t'(64'sd33543515);
      5'd6:  v = cw_t'(64'sd16775850);
      5'd7:  v = cw_t'(64'sd8388437);
      5'd8:  v = cw_t'(64'sd4194282);
      5'd9:  v = cw_t'(64'sd2097149);
      5'd10: v = cw_t'(64'sd1048575);
      5'd11: v = cw_t'(64'sd524287);
      5'd12: v = cw_t'(64'sd262143);
      5'd13: v = cw_t'(64'sd131071);
      5'd14: v = cw_t'(64'sd65535);
      5'd15: v = cw_t'(64'sd32767);
      5'd16: v = cw_t'(64'sd16383);
      5'd17: v = cw_t'(64'sd8191);
      5'd18: v = cw_t'(64'sd4095);
      5'd19: v = cw_t'(64'sd2047);
      5'd20: v = cw_t'(64'sd1023);
      5'd21: v = cw_t'(64'sd511);
      5'd22: v = cw_t'(64'sd255);
      5'd23: v = cw_t'(64'sd127);
      5'd24: v = cw_t'(64'sd63);
      5'd25: v = cw_t'(64'sd31);
      5'd26: v = cw_t'(64'sd15);
      5'd27: v = cw_t'(64'sd7);
      5'd28: v = cw_t'(64'sd3);
      5'd29: v = cw_t'(64'sd1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic cw_t mul_q30(input cw_t a, input cw_t b);
    logic signed [2*W-1:0] p;
    p = (2*W)'(a) * (2*W)'(b) + (2*W)'(64'sd536870912);
    return cw_t'(p >>> 30);
  endfunction

endpackage

// ----- design/hav_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_cell
// One CORDIC micro-rotation stage, rotation or vectoring mode, registered.
// ----------------------------------------------------------------------------
module hav_cell (
  input  logic              clk,
  input  logic              en,
  input  logic              vec,
  input  logic [hav_pkg::SH_W-1:0] shift,
  input  hav_pkg::cw_t      x_in,
  input  hav_pkg::cw_t      y_in,
  input  hav_pkg::cw_t      z_in,
  output hav_pkg::cw_t      x,
  output hav_pkg::cw_t      y,
  output hav_pkg::cw_t      z
);

  logic         up;
  hav_pkg::cw_t xs;
  hav_pkg::cw_t ys;
  hav_pkg::cw_t at;

  assign up = vec ? y_in[hav_pkg::W-1] : !z_in[hav_pkg::W-1];
  assign xs = x_in >>> shift;
  assign ys = y_in >>> shift;
  assign at = hav_pkg::atan_q30(shift);

  always_ff @(posedge clk) begin
    if (en) begin
      if (up) begin
        x <= x_in - ys;
        y <= y_in + xs;
        z <= z_in - at;
      end else begin
        x <= x_in + ys;
        y <= y_in - xs;
        z <= z_in + at;
      end
    end
  end

endmodule

// ----- design/hav_fold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_fold
// Wrap an angle into [-pi, pi] and fold it into [-pi/2, pi/2], flag a cosine
// sign flip.
// ----------------------------------------------------------------------------
module hav_fold (
  input  logic         clk,
  input  logic         en,
  input  hav_pkg::cw_t a,
  output hav_pkg::cw_t r,
  output logic         neg
);

  hav_pkg::cw_t w;
  hav_pkg::cw_t r_next;
  logic         neg_next;

  always_comb begin
    w = a;
    if (a > hav_pkg::Q30_PI) begin
      w = a - hav_pkg::TWO_PI;
    end else if (a < -hav_pkg::Q30_PI) begin
      w = a + hav_pkg::TWO_PI;
    end
    r_next   = w;
    neg_next = 1'b0;
    if (w > hav_pkg::HALF_PI) begin
      r_next   = hav_pkg::Q30_PI - w;
      neg_next = 1'b1;
    end else if (w < -hav_pkg::HALF_PI) begin
      r_next   = -hav_pkg::Q30_PI - w;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r   <= r_next;
      neg <= neg_next;
    end
  end

endmodule

// ----- design/hav_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_sqrt_cell
// One digit step of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module hav_sqrt_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hav_pkg::RAD_W-1:0]    n_in,
  input  logic [hav_pkg::REM_W-1:0]    rem_in,
  input  logic [hav_pkg::ROOT_W-1:0]   root_in,
  output logic [hav_pkg::RAD_W-1:0]    n,
  output logic [hav_pkg::REM_W-1:0]    rem,
  output logic [hav_pkg::ROOT_W-1:0]   root
);

  logic [hav_pkg::REM_W+1:0] cur;
  logic [hav_pkg::REM_W+1:0] trial;

  assign cur   = {rem_in, n_in[hav_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root_in, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      n <= {n_in[hav_pkg::RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem  <= hav_pkg::REM_W'(cur - trial);
        root <= {root_in[hav_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= hav_pkg::REM_W'(cur);
        root <= {root_in[hav_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- design/great_circle_haversine_distance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_haversine_distance
// Haversine great-circle distance on a 6371 km sphere, fixed point, built as
// rows of CORDIC and square-root cells.
// ----------------------------------------------------------------------------
//  channel  dir  content
//  s_axis   in   lat_a, lon_a, lat_b, lon_b (Q28 radians)
//  m_axis   out  distance_km (Q16 km), arg_saturated in tuser
//
//  One transfer per cycle sustained while m_axis accepts; the path runs through
//  the sine/cosine row, the square-root row and the arctangent row.
//  Reset clears the valid line and holds s_axis_tready low.
//  A stall on m_axis freezes the whole pipe.
// ----------------------------------------------------------------------------
module great_circle_haversine_distance (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // lat_a, lon_a, lat_b, lon_b, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // distance_km, zero pad
  output logic         m_axis_tuser    // arg_saturated
);

  localparam int CS = hav_pkg::CORDIC_STAGES;
  localparam int SQ = hav_pkg::SQRT_STAGES;
  localparam int W  = hav_pkg::W;

  logic en;
  logic [hav_pkg::PIPE_DEPTH-1:0] vld;

  logic signed [hav_pkg::LAT_W-1:0] lat_a;
  logic signed [hav_pkg::LON_W-1:0] lon_a;
  logic signed [hav_pkg::LAT_W-1:0] lat_b;
  logic signed [hav_pkg::LON_W-1:0] lon_b;

  hav_pkg::cw_t ang [4];
  hav_pkg::cw_t fr  [4];
  logic         fneg [4];

  hav_pkg::cw_t cx [4][CS+1];
  hav_pkg::cw_t cy [4][CS+1];
  hav_pkg::cw_t cz [4][CS+1];

  logic [CS-1:0] nega_line;
  logic [CS-1:0] negb_line;

  hav_pkg::cw_t ca;
  hav_pkg::cw_t cb;
  hav_pkg::cw_t uu;
  hav_pkg::cw_t vv;
  hav_pkg::cw_t cc;
  hav_pkg::cw_t uu2;
  hav_pkg::cw_t tt;
  hav_pkg::cw_t hs;
  logic [hav_pkg::ROOT_W-1:0] hq;
  logic [hav_pkg::SAT_DEPTH:0] sat_line;

  logic [hav_pkg::RAD_W-1:0]  sn [2][SQ+1];
  logic [hav_pkg::REM_W-1:0]  sr [2][SQ+1];
  logic [hav_pkg::ROOT_W-1:0] so [2][SQ+1];

  hav_pkg::cw_t vx [CS+1];
  hav_pkg::cw_t vy [CS+1];
  hav_pkg::cw_t vz [CS+1];

  logic [W-2:0] zc;
  logic [hav_pkg::PROD_W-1:0] prod;
  logic [32:0] dr;
  logic [hav_pkg::DIST_W-1:0] distance;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign m_axis_tvalid = vld[hav_pkg::PIPE_DEPTH-1];
  assign m_axis_tdata  = {1'b0, distance};
  assign m_axis_tuser  = sat_line[hav_pkg::SAT_DEPTH];

  assign lat_a = s_axis_tdata[29:0];
  assign lon_a = s_axis_tdata[60:30];
  assign lat_b = s_axis_tdata[90:61];
  assign lon_b = s_axis_tdata[121:91];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[hav_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang[0] <= (W'(lat_b) - W'(lat_a)) <<< hav_pkg::HALF_SH;
      ang[1] <= (W'(lon_b) - W'(lon_a)) <<< hav_pkg::HALF_SH;
      ang[2] <= W'(lat_a) <<< hav_pkg::FULL_SH;
      ang[3] <= W'(lat_b) <<< hav_pkg::FULL_SH;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_rot
    hav_fold u_fold (
      .clk (clk),
      .en  (en),
      .a   (ang[k]),
      .r   (fr[k]),
      .neg (fneg[k])
    );
    assign cx[k][0] = hav_pkg::GAIN_INV;
    assign cy[k][0] = '0;
    assign cz[k][0] = fr[k];
    for (genvar i = 0; i < CS; i++) begin : g_st
      hav_cell u_cell (
        .clk   (clk),
        .en    (en),
        .vec   (1'b0),
        .shift (hav_pkg::SH_W'(i)),
        .x_in  (cx[k][i]),
        .y_in  (cy[k][i]),
        .z_in  (cz[k][i]),
        .x     (cx[k][i+1]),
        .y     (cy[k][i+1]),
        .z     (cz[k][i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nega_line <= {nega_line[CS-2:0], fneg[2]};
      negb_line <= {negb_line[CS-2:0], fneg[3]};
    end
  end

  assign ca = nega_line[CS-1] ? -cx[2][CS] : cx[2][CS];
  assign cb = negb_line[CS-1] ? -cx[3][CS] : cx[3][CS];
  assign hs = uu2 + tt;

  always_ff @(posedge clk) begin
    if (en) begin
      uu  <= hav_pkg::mul_q30(cy[0][CS], cy[0][CS]);
      vv  <= hav_pkg::mul_q30(cy[1][CS], cy[1][CS]);
      cc  <= hav_pkg::mul_q30(ca, cb);
      uu2 <= uu;
      tt  <= hav_pkg::mul_q30(cc, vv);
      if (hs[W-1]) begin
        hq <= '0;
      end else if (hs >= hav_pkg::Q30_ONE) begin
        hq <= hav_pkg::ROOT_W'(hav_pkg::Q30_ONE);
      end else begin
        hq <= hav_pkg::ROOT_W'(hs);
      end
      sat_line <= {sat_line[hav_pkg::SAT_DEPTH-1:0],
                   !hs[W-1] && (hs >= hav_pkg::Q30_ONE)};
    end
  end

  assign sn[0][0] = hav_pkg::RAD_W'(hq) << 30;
  assign sn[1][0] = hav_pkg::RAD_W'(hav_pkg::ROOT_W'(hav_pkg::Q30_ONE) - hq) << 30;

  for (genvar k = 0; k < 2; k++) begin : g_sq
    assign sr[k][0] = '0;
    assign so[k][0] = '0;
    for (genvar i = 0; i < SQ; i++) begin : g_st
      hav_sqrt_cell u_sq (
        .clk     (clk),
        .en      (en),
        .n_in    (sn[k][i]),
        .rem_in  (sr[k][i]),
        .root_in (so[k][i]),
        .n       (sn[k][i+1]),
        .rem     (sr[k][i+1]),
        .root    (so[k][i+1])
      );
    end
  end

  assign vx[0] = W'(so[1][SQ]);
  assign vy[0] = W'(so[0][SQ]);
  assign vz[0] = '0;

  for (genvar i = 0; i < CS; i++) begin : g_vec
    hav_cell u_cell (
      .clk   (clk),
      .en    (en),
      .vec   (1'b1),
      .shift (hav_pkg::SH_W'(i)),
      .x_in  (vx[i]),
      .y_in  (vy[i]),
      .z_in  (vz[i]),
      .x     (vx[i+1]),
      .y     (vy[i+1]),
      .z     (vz[i+1])
    );
  end

  assign zc = vz[CS][W-1] ? '0 : vz[CS][W-2:0];
  assign dr = 33'((prod + hav_pkg::PROD_W'(8192)) >> 14);

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= hav_pkg::PROD_W'(zc) * hav_pkg::PROD_W'(hav_pkg::RAD2);
      distance <= (dr > hav_pkg::DIST_MAX) ? hav_pkg::DIST_W'(hav_pkg::DIST_MAX)
                                           : hav_pkg::DIST_W'(dr);
    end
  end

endmodule
